// ----- rtl/lrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrb_pkg
// shared types, register offsets and constants of the display register block
// ----------------------------------------------------------------------------
package lrb_pkg;

    localparam int DataW   = 16;
    localparam int OffW    = 12;
    localparam int VramW   = 13;
    localparam int StrideW = 18;
    localparam int BaseW   = 34;
    localparam int EnW     = 8;

    // register window offsets
    localparam logic [OffW-1:0] OFF_VERSION = 12'h500;
    localparam logic [OffW-1:0] OFF_XRES    = 12'h502;
    localparam logic [OffW-1:0] OFF_YRES    = 12'h504;
    localparam logic [OffW-1:0] OFF_BPP     = 12'h506;
    localparam logic [OffW-1:0] OFF_ENABLE  = 12'h508;
    localparam logic [OffW-1:0] OFF_VWIDTH  = 12'h50C;
    localparam logic [OffW-1:0] OFF_VHEIGHT = 12'h50E;
    localparam logic [OffW-1:0] OFF_XOFF    = 12'h510;
    localparam logic [OffW-1:0] OFF_YOFF    = 12'h512;
    localparam logic [OffW-1:0] OFF_VRAM    = 12'h514;
    localparam logic [OffW-1:0] OFF_EXTSIZE = 12'h600;
    localparam logic [OffW-1:0] OFF_ENDIAN0 = 12'h604;
    localparam logic [OffW-1:0] OFF_ENDIAN1 = 12'h606;

    // operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [EnW-1:0]   ENABLE_MASK = 8'hE3;
    localparam int               EN_ON_BIT   = 0;
    localparam int               EN_CAPS_BIT = 1;
    localparam int               EN_NOCLR_BIT = 7;
    localparam logic [DataW-1:0] VER_MIN     = 16'hB0C0;
    localparam logic [DataW-1:0] VER_MAX     = 16'hB0C5;
    localparam logic [DataW-1:0] CAPS_XRES   = 16'd2560;
    localparam logic [DataW-1:0] CAPS_YRES   = 16'd1440;
    localparam logic [DataW-1:0] BPP_WORD    = 16'd32;
    localparam logic [DataW-1:0] EXT_WORD    = 16'd8;
    localparam logic [DataW-1:0] ENDIAN_WORD = 16'h1E1E;
    localparam logic [VramW-1:0] VRAM_RESET  = 13'd256;

    typedef struct packed {
        logic             op;
        logic [OffW-1:0]  offset;
        logic [DataW-1:0] data;
    } req_t;

    typedef struct packed {
        logic [DataW-1:0]   read_data;
        logic [DataW-1:0]   width;
        logic [DataW-1:0]   height;
        logic [StrideW-1:0] stride;
        logic [BaseW-1:0]   base;
        logic               clear_vram;
        logic               mode_updated;
    } rsp_t;

endpackage : lrb_pkg
`default_nettype wire

// ----- rtl/lrb_scan_calc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrb_scan_calc
// scanout stride and start offset from width, virtual width and panning
// ----------------------------------------------------------------------------
module lrb_scan_calc (
    input  wire logic [lrb_pkg::DataW-1:0]   width,
    input  wire logic [lrb_pkg::DataW-1:0]   virt_width,
    input  wire logic [lrb_pkg::DataW-1:0]   x_off,
    input  wire logic [lrb_pkg::DataW-1:0]   y_off,
    output logic      [lrb_pkg::StrideW-1:0] stride,
    output logic      [lrb_pkg::BaseW-1:0]   base
);
    import lrb_pkg::*;

    logic [StrideW-1:0] packed_w;
    logic [StrideW-1:0] virt_ext;
    logic [BaseW-1:0]   product;
    logic [BaseW:0]     sum;

    // 32 bits per pixel
    assign packed_w = {width, 2'b00};
    assign virt_ext = {{(StrideW-DataW){1'b0}}, virt_width};
    assign stride   = (virt_ext > packed_w) ? virt_ext : packed_w;
    assign product  = BaseW'(y_off * stride);
    assign sum      = {1'b0, product} + {{(BaseW+1-DataW){1'b0}}, x_off};
    assign base     = sum[BaseW-1:0];

endmodule : lrb_scan_calc
`default_nettype wire

// ----- rtl/lrb_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrb_regs
// register file, access decode and scanout state update
// ----------------------------------------------------------------------------
module lrb_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire lrb_pkg::req_t              req,
    input  wire logic [lrb_pkg::VramW-1:0]  vram_size_units,
    output lrb_pkg::rsp_t                   rsp
);
    import lrb_pkg::*;

    logic [DataW-1:0]   version_reg, version_next;
    logic [EnW-1:0]     enable_reg, enable_next;
    logic [DataW-1:0]   xres_reg, xres_next;
    logic [DataW-1:0]   yres_reg, yres_next;
    logic [DataW-1:0]   vwidth_reg, vwidth_next;
    logic [DataW-1:0]   vheight_reg, vheight_next;
    logic [DataW-1:0]   xoff_reg, xoff_next;
    logic [DataW-1:0]   yoff_reg, yoff_next;
    logic [DataW-1:0]   width_reg, width_next;
    logic [DataW-1:0]   height_reg, height_next;
    logic [StrideW-1:0] stride_reg, stride_next;
    logic [BaseW-1:0]   base_reg, base_next;

    logic               wr;
    logic               load_res;
    logic               recompute;
    logic [DataW-1:0]   width_src;
    logic [DataW-1:0]   height_src;
    logic [StrideW-1:0] calc_stride;
    logic [BaseW-1:0]   calc_base;
    logic [DataW-1:0]   rd;

    assign wr = (req.op == OP_WRITE);

    always_comb
    begin
        version_next = version_reg;
        enable_next  = enable_reg;
        xres_next    = xres_reg;
        yres_next    = yres_reg;
        vwidth_next  = vwidth_reg;
        vheight_next = vheight_reg;
        xoff_next    = xoff_reg;
        yoff_next    = yoff_reg;
        load_res     = 1'b0;
        recompute    = 1'b0;
        if (wr)
        begin
            unique case (req.offset)
                OFF_VERSION: version_next = req.data;
                OFF_XRES:
                begin
                    if (!enable_reg[EN_ON_BIT])
                        xres_next = req.data;
                end
                OFF_YRES:
                begin
                    if (!enable_reg[EN_ON_BIT])
                        yres_next = req.data;
                end
                OFF_ENABLE:
                begin
                    enable_next = req.data[EnW-1:0] & ENABLE_MASK;
                    load_res    = req.data[EN_ON_BIT];
                    recompute   = req.data[EN_ON_BIT];
                end
                OFF_VWIDTH:
                begin
                    vwidth_next = req.data;
                    recompute   = 1'b1;
                end
                OFF_VHEIGHT: vheight_next = req.data;
                OFF_XOFF:
                begin
                    xoff_next = req.data;
                    recompute = 1'b1;
                end
                OFF_YOFF:
                begin
                    yoff_next = req.data;
                    recompute = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // enable loads the held geometry from the resolution registers
    assign width_src  = load_res ? xres_reg : width_reg;
    assign height_src = load_res ? yres_reg : height_reg;

    lrb_scan_calc u_scan_calc (
        .width      (width_src),
        .virt_width (vwidth_next),
        .x_off      (xoff_next),
        .y_off      (yoff_next),
        .stride     (calc_stride),
        .base       (calc_base)
    );

    assign width_next  = recompute ? width_src   : width_reg;
    assign height_next = recompute ? height_src  : height_reg;
    assign stride_next = recompute ? calc_stride : stride_reg;
    assign base_next   = recompute ? calc_base   : base_reg;

    // read mux on the state before the access
    always_comb
    begin
        rd = '0;
        if (!wr)
        begin
            case (req.offset)
                OFF_VERSION:
                    rd = ((version_reg < VER_MIN) || (version_reg > VER_MAX)) ?
                         VER_MAX : version_reg;
                OFF_XRES:    rd = enable_reg[EN_CAPS_BIT] ? CAPS_XRES : xres_reg;
                OFF_YRES:    rd = enable_reg[EN_CAPS_BIT] ? CAPS_YRES : yres_reg;
                OFF_BPP:     rd = BPP_WORD;
                OFF_ENABLE:  rd = {{(DataW-EnW){1'b0}}, enable_reg};
                OFF_VWIDTH:  rd = vwidth_reg;
                OFF_VHEIGHT: rd = vheight_reg;
                OFF_XOFF:    rd = xoff_reg;
                OFF_YOFF:    rd = yoff_reg;
                OFF_VRAM:    rd = {{(DataW-VramW){1'b0}}, vram_size_units};
                OFF_EXTSIZE: rd = EXT_WORD;
                OFF_ENDIAN0, OFF_ENDIAN1: rd = ENDIAN_WORD;
                default:     rd = '0;
            endcase
        end
    end

    always_comb
    begin
        rsp.read_data    = rd;
        rsp.width        = width_next;
        rsp.height       = height_next;
        rsp.stride       = stride_next;
        rsp.base         = base_next;
        rsp.clear_vram   = load_res && !req.data[EN_NOCLR_BIT];
        rsp.mode_updated = recompute;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= '0;
            enable_reg  <= '0;
            xres_reg    <= '0;
            yres_reg    <= '0;
            vwidth_reg  <= '0;
            vheight_reg <= '0;
            xoff_reg    <= '0;
            yoff_reg    <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            stride_reg  <= '0;
            base_reg    <= '0;
        end
        else if (fire)
        begin
            version_reg <= version_next;
            enable_reg  <= enable_next;
            xres_reg    <= xres_next;
            yres_reg    <= yres_next;
            vwidth_reg  <= vwidth_next;
            vheight_reg <= vheight_next;
            xoff_reg    <= xoff_next;
            yoff_reg    <= yoff_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            stride_reg  <= stride_next;
            base_reg    <= base_next;
        end
    end

endmodule : lrb_regs
`default_nettype wire

// ----- rtl/linear_display_register_block.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_display_register_block
// linear framebuffer display register window with scanout geometry
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one 16-bit register access:
//   operation (0 read, 1 write), reg_offset and write_data
//   output channel (out_valid/out_ready) returns one result per access:
//   read_data plus the scanout geometry after the access and two flags
//   cfg_we/cfg_wdata load the video memory size; write it only while idle
// path: input register, then decode/update/multiply into result register
// throughput: one transaction per cycle when not stalled; the state
//   register loop (decode, stride compare, one 16x18 multiply, add) sets it
// stall: a held result keeps the pending access in the input register,
//   and in_ready drops only once both stages are full
// reset: all display registers and scanout geometry clear to zero, the
//   video memory size returns to 256 units, both stages empty
// ----------------------------------------------------------------------------
module linear_display_register_block (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic [lrb_pkg::OffW-1:0]      reg_offset,
    input  wire logic [lrb_pkg::DataW-1:0]     write_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [lrb_pkg::DataW-1:0]     read_data,
    output logic      [lrb_pkg::DataW-1:0]     scan_width,
    output logic      [lrb_pkg::DataW-1:0]     scan_height,
    output logic      [lrb_pkg::StrideW-1:0]   scan_stride,
    output logic      [lrb_pkg::BaseW-1:0]     scan_base,
    output logic                               clear_vram,
    output logic                               mode_updated,
    input  wire logic                          cfg_we,
    input  wire logic [lrb_pkg::VramW-1:0]     cfg_wdata
);
    import lrb_pkg::*;

    // configuration register
    logic [VramW-1:0] vram_reg;

    // input stage
    logic             req_valid_reg;
    req_t             req_reg;

    // result stage
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    rsp_t             rsp_next;
    logic             fire;

    // the access retires when the result register is free or being drained
    assign fire     = req_valid_reg && (!rsp_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vram_reg <= VRAM_RESET;
        else if (cfg_we)
            vram_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (in_ready)
            req_valid_reg <= in_valid;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg.op     <= operation;
            req_reg.offset <= reg_offset;
            req_reg.data   <= write_data;
        end
    end

    lrb_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .req             (req_reg),
        .vram_size_units (vram_reg),
        .rsp             (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (fire)
            rsp_valid_reg <= 1'b1;
        else if (out_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign out_valid    = rsp_valid_reg;
    assign read_data    = rsp_reg.read_data;
    assign scan_width   = rsp_reg.width;
    assign scan_height  = rsp_reg.height;
    assign scan_stride  = rsp_reg.stride;
    assign scan_base    = rsp_reg.base;
    assign clear_vram   = rsp_reg.clear_vram;
    assign mode_updated = rsp_reg.mode_updated;

endmodule : linear_display_register_block
`default_nettype wire
